// ===== sv/i2c_master_register_access_assert.svh =====
// Assertion macros for the I2C register access block
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
// implication checked every clock, quiet in reset
`define IMRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imra check failed");
// next-cycle implication
`define IMRA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imra check failed");
`endif

// ===== sv/imra_pkg.sv =====
// ----------------------------------------------------------------------------
// imra_pkg
// Types and codes shared by the I2C register access block.
// ----------------------------------------------------------------------------
`default_nettype none
package imra_pkg;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic       REG_HALF_BIT = 1'b0;
	localparam logic       REG_ACK_TMO  = 1'b1;
	localparam logic [7:0] HALF_BIT_RST = 8'd20;
	localparam logic [7:0] ACK_TMO_RST  = 8'd255;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_sample;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} out_item_t;

	typedef struct packed {
		logic       start;
		logic       rd;
		logic [7:0] dev;
		logic [7:0] regad;
		logic [7:0] data;
		logic       sda;
	} tick_t;
endpackage
`default_nettype wire

// ===== sv/imra_front.sv =====
// ----------------------------------------------------------------------------
// imra_front
// Classifies each incoming tick and queues it for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module imra_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  imra_pkg::in_item_t     item,
	output logic                   full,
	input  wire logic              take,
	output logic                   avail,
	output imra_pkg::tick_t        tick
);
	import imra_pkg::*;
	tick_t      mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q[2];
	assign avail   = cnt_q != 3'd0;
	assign do_push = push && !full;
	assign do_pop  = take && avail;
	assign tick    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q].start <= item.command == CMD_WRITE || item.command == CMD_READ;
			mem_q[wr_q].rd    <= item.command == CMD_READ;
			mem_q[wr_q].dev   <= item.device_address;
			mem_q[wr_q].regad <= item.register_address;
			mem_q[wr_q].data  <= item.write_data;
			mem_q[wr_q].sda   <= item.sda_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 2'd1;
			if (do_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, do_push} - {2'd0, do_pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/imra_seq.sv =====
// ----------------------------------------------------------------------------
// imra_seq
// Bus phase sequencer: one queued tick in, one bus result out.
// ----------------------------------------------------------------------------
`default_nettype none
module imra_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  imra_pkg::tick_t    tick,
	input  wire logic [7:0]    half_bit,
	input  wire logic [7:0]    ack_tmo,
	output imra_pkg::out_item_t res
);
	import imra_pkg::*;
	`include "i2c_master_register_access_assert.svh"

	typedef enum logic [21:0] {
		PH_IDLE = 22'd1 << 0,  PH_ST0 = 22'd1 << 1,  PH_ST1 = 22'd1 << 2,
		PH_ST2  = 22'd1 << 3,  PH_BL1 = 22'd1 << 4,  PH_BL2 = 22'd1 << 5,
		PH_BH   = 22'd1 << 6,  PH_WE0 = 22'd1 << 7,  PH_WE1 = 22'd1 << 8,
		PH_AS   = 22'd1 << 9,  PH_AW  = 22'd1 << 10, PH_AL  = 22'd1 << 11,
		PH_R0   = 22'd1 << 12, PH_RH  = 22'd1 << 13, PH_RL  = 22'd1 << 14,
		PH_RX   = 22'd1 << 15, PH_N0  = 22'd1 << 16, PH_N1  = 22'd1 << 17,
		PH_N2   = 22'd1 << 18, PH_SP0 = 22'd1 << 19, PH_SP1 = 22'd1 << 20,
		PH_SP2  = 22'd1 << 21
	} phase_t;

	phase_t     phase_q, ph, ph_n;
	logic [3:0] bit_q, bit_n, bc;
	logic [2:0] bstep_q, bstep_n, bs;
	logic [7:0] shift_q, shift_n, sh;
	logic [7:0] timer_q, timer_n;
	logic [7:0] wait_q, wait_n, wait_inc;
	logic [7:0] dev_q, reg_q, dat_q, dev_n, reg_n, dat_n, rx_q, rx_n;
	logic       rd_q, rd_n, err_q, err_n, hold_q, hold_n;
	logic       scl, sdal, drv, done;
	logic [7:0] hb1, tmo1;
	logic [8:0] t;

	assign hb1  = (half_bit == 8'd0) ? 8'd1 : half_bit;
	assign tmo1 = (ack_tmo == 8'd0) ? 8'd1 : ack_tmo;

	always_comb begin
		ph = phase_q; bc = bit_q; bs = bstep_q; sh = shift_q;
		dev_n = dev_q; reg_n = reg_q; dat_n = dat_q; rd_n = rd_q;
		err_n = err_q; timer_n = timer_q; wait_n = wait_q; rx_n = rx_q;
		if (phase_q == PH_IDLE && tick.start) begin
			dev_n = tick.dev; reg_n = tick.regad; dat_n = tick.data; rd_n = tick.rd;
			err_n = 1'b0; bs = 3'd0; bc = 4'd0; timer_n = 8'd0; ph = PH_ST0;
		end
		scl = 1'b1; sdal = 1'b1; drv = 1'b1; done = 1'b0;
		case (ph)
			PH_ST0: scl = bs == 3'd0;
			PH_ST2: sdal = 1'b0;
			PH_BL1, PH_WE0: begin scl = 1'b0; sdal = hold_q; end
			PH_BL2: begin scl = 1'b0; sdal = sh[7]; end
			PH_BH: sdal = sh[7];
			PH_WE1, PH_N0, PH_N2: scl = 1'b0;
			PH_AS, PH_AW, PH_RH: drv = 1'b0;
			PH_AL, PH_R0, PH_RL, PH_RX: begin scl = 1'b0; drv = 1'b0; end
			PH_SP0: begin scl = 1'b0; sdal = 1'b0; end
			PH_SP1: sdal = 1'b0;
			default: ;
		endcase
		hold_n = drv ? sdal : hold_q;
		ph_n = ph; bit_n = bc; bstep_n = bs; shift_n = sh;
		wait_inc = (wait_q == 8'd255) ? wait_q : wait_q + 8'd1;
		t = {1'b0, timer_n} + 9'd1;
		if (ph == PH_AW) begin
			if (!tick.sda) begin
				ph_n = PH_AL; timer_n = 8'd0;
			end else begin
				wait_n = wait_inc;
				if (wait_inc >= tmo1) begin
					err_n = 1'b1; ph_n = PH_SP0; timer_n = 8'd0;
				end
			end
		end else if (ph != PH_IDLE) begin
			if (t >= {1'b0, hb1}) begin
				timer_n = 8'd0;
				case (ph)
					PH_ST0: ph_n = PH_ST1;
					PH_ST1: ph_n = PH_ST2;
					PH_ST2: begin
						shift_n = bs == 3'd0 ? dev_n : (dev_n | 8'd1);
						if (bs != 3'd0) bstep_n = 3'd3;
						bit_n = 4'd0; ph_n = PH_BL1;
					end
					PH_BL1: ph_n = PH_BL2;
					PH_BL2: ph_n = PH_BH;
					PH_BH: begin
						shift_n = {sh[6:0], 1'b0}; bit_n = bc + 4'd1;
						ph_n = (bc + 4'd1 >= 4'd8) ? PH_WE0 : PH_BL1;
					end
					PH_WE0: ph_n = PH_WE1;
					PH_WE1: ph_n = PH_AS;
					PH_AS: begin wait_n = 8'd0; ph_n = PH_AW; end
					PH_AL: begin
						if (bs == 3'd0) begin
							bstep_n = 3'd1; shift_n = reg_n; bit_n = 4'd0; ph_n = PH_BL1;
						end else if (bs == 3'd1) begin
							bstep_n = 3'd2;
							if (rd_n) ph_n = PH_ST0;
							else begin shift_n = dat_n; bit_n = 4'd0; ph_n = PH_BL1; end
						end else if (bs == 3'd3) begin
							bstep_n = 3'd4; shift_n = 8'd0; bit_n = 4'd0; ph_n = PH_R0;
						end else ph_n = PH_SP0;
					end
					PH_R0: ph_n = PH_RH;
					PH_RH: begin
						shift_n = {sh[6:0], tick.sda}; bit_n = bc + 4'd1; ph_n = PH_RL;
					end
					PH_RL: ph_n = (bc >= 4'd8) ? PH_RX : PH_RH;
					PH_RX: begin rx_n = sh; ph_n = PH_N0; end
					PH_N0: ph_n = PH_N1;
					PH_N1: ph_n = PH_N2;
					PH_N2: ph_n = PH_SP0;
					PH_SP0: ph_n = PH_SP1;
					PH_SP1: ph_n = PH_SP2;
					PH_SP2: begin ph_n = PH_IDLE; done = 1'b1; end
					default: ph_n = PH_IDLE;
				endcase
			end else timer_n = t[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bit_q <= '0; bstep_q <= '0; shift_q <= '0;
			timer_q <= '0; wait_q <= '0; dev_q <= '0; reg_q <= '0; dat_q <= '0;
			rd_q <= 1'b0; rx_q <= '0; err_q <= 1'b0; hold_q <= 1'b1;
		end else if (step) begin
			phase_q <= ph_n; bit_q <= bit_n; bstep_q <= bstep_n; shift_q <= shift_n;
			timer_q <= timer_n; wait_q <= wait_n; dev_q <= dev_n; reg_q <= reg_n;
			dat_q <= dat_n; rd_q <= rd_n; rx_q <= rx_n; err_q <= err_n; hold_q <= hold_n;
		end
	end

	assign res = '{scl_level: scl, sda_level: drv ? sdal : 1'b1, sda_drive: drv,
		busy_res: ph_n != PH_IDLE, done_res: done, read_data: rx_n,
		ack_missing: err_n};

	`IMRA_ASSERT_IMP(a_onehot, 1'b1, $onehot(phase_q))
	`IMRA_ASSERT_IMP(a_done_idle, step && done, ph_n == PH_IDLE)
	`IMRA_ASSERT_IMP(a_bits, 1'b1, bit_q <= 4'd8)
	`IMRA_ASSERT_NXT(a_hold, !step, $stable(phase_q))
endmodule
`default_nettype wire

// ===== sv/imra_back.sv =====
// ----------------------------------------------------------------------------
// imra_back
// Result register with a skid stage towards the result queue port.
// ----------------------------------------------------------------------------
`default_nettype none
module imra_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            avail,
	output logic                 step,
	input  imra_pkg::out_item_t  res,
	output imra_pkg::out_item_t  result,
	output logic                 empty,
	input  wire logic            pop
);
	import imra_pkg::*;
	out_item_t r0_q, r1_q;
	logic      v0_q, v1_q, deq;

	assign deq    = pop && v0_q;
	assign empty  = !v0_q;
	assign result = r0_q;
	assign step   = avail && !v1_q;

	always_ff @(posedge clk) begin
		if (deq || !v0_q) r0_q <= v1_q ? r1_q : res;
		if (step && v0_q && !deq) r1_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (deq || !v0_q) begin
				v0_q <= v1_q || step;
				v1_q <= 1'b0;
			end else if (step) v1_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== sv/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master running single-byte register write and read transactions.
// ----------------------------------------------------------------------------
// Channel  | Handshake        | Payload
// ticks in | push / full      | in_item (command, addresses, data, sda)
// results  | pop / empty      | out_item (bus levels, status, read data)
// config   | cfg_we           | cfg_index, cfg_data
//
// One tick enters per cycle while full is low; each tick is held in a 4-deep
// tick queue, stepped through the phase sequencer and its result registered in a
// two-entry result buffer. A transaction starts only from idle.
// Reset returns the bus to released and loads default timings.
// A stalled result side fills the buffer, then the queue, then raises full.
`default_nettype none
module i2c_master_register_access (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  imra_pkg::in_item_t     in_item,
	output logic                   empty,
	input  wire logic              pop,
	output imra_pkg::out_item_t    out_item,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data
);
	import imra_pkg::*;
	logic [7:0] half_bit_q, ack_tmo_q;
	logic       take, avail;
	tick_t      tick;
	out_item_t  res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RST;
			ack_tmo_q  <= ACK_TMO_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_HALF_BIT) half_bit_q <= cfg_data;
			if (cfg_index == REG_ACK_TMO) ack_tmo_q <= cfg_data;
		end
	end

	imra_front u_front (.clk, .arst_n, .push, .item(in_item), .full,
		.take, .avail, .tick);
	imra_seq u_seq (.clk, .arst_n, .step(take), .tick, .half_bit(half_bit_q),
		.ack_tmo(ack_tmo_q), .res);
	imra_back u_back (.clk, .arst_n, .avail, .step(take), .res, .result(out_item),
		.empty, .pop);
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C register access master: drives bus ticks
// through the push/full queue, predicts every result tick and compares it
// against what pops out, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import imra_pkg::*;

	// sequencer phases
	typedef enum logic [5:0] {
		P_IDLE, P_ST0, P_ST1, P_ST2, P_BL1, P_BL2, P_BH, P_WE0, P_WE1, P_AS, P_AW,
		P_AL, P_R0, P_RH, P_RL, P_RX, P_N0, P_N1, P_N2, P_SP0, P_SP1, P_SP2
	} bus_phase_e;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int         CYCLE_LIMIT = 50000;
	localparam int         ITEM_TARGET = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	i2c_master_register_access u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted bus model state
	logic [7:0] m_half, m_tmo;
	bus_phase_e m_phase;
	logic [3:0] m_bits;
	logic [2:0] m_step;
	logic [7:0] m_shift, m_timer, m_ackw, m_dev, m_reg, m_data, m_rxbyte;
	logic m_rd, m_err, m_sda_hold;

	out_item_t expected_ticks[$];
	int errors = 0;
	int cycles = 0;
	int sent = 0;
	bit stall_rx = 1'b0;   // long receiver hold-off
	bit rx_no_idle = 1'b0; // stretch with no idling
	bit tx_no_idle = 1'b0;

	// slave behaviour used by the random part
	int ack_miss_pct = 10;

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
	endtask

	function automatic logic [7:0] ge1(input logic [7:0] v);
		return (v == 0) ? 8'd1 : v;
	endfunction

	task automatic model_reset();
		m_half = HALF_BIT_RST; m_tmo = ACK_TMO_RST;
		m_phase = P_IDLE; m_bits = 0; m_step = 0; m_shift = 0; m_timer = 0;
		m_ackw = 0; m_dev = 0; m_reg = 0; m_data = 0; m_rd = 0; m_rxbyte = 0;
		m_err = 0; m_sda_hold = 1;
	endtask

	task automatic load_byte(input logic [7:0] b);
		m_shift = b; m_bits = 0; m_phase = P_BL1;
	endtask

	task automatic advance_phase(input logic sda);
		case (m_phase)
			P_ST0: m_phase = P_ST1;
			P_ST1: m_phase = P_ST2;
			P_ST2: begin
				if (m_step == 0) load_byte(m_dev);
				else begin
					m_step = 3;
					load_byte(m_dev | 8'd1);
				end
			end
			P_BL1: m_phase = P_BL2;
			P_BL2: m_phase = P_BH;
			P_BH: begin
				m_shift = m_shift << 1;
				m_bits = m_bits + 1;
				m_phase = (m_bits >= 8) ? P_WE0 : P_BL1;
			end
			P_WE0: m_phase = P_WE1;
			P_WE1: m_phase = P_AS;
			P_AS: begin
				m_ackw = 0; m_phase = P_AW;
			end
			P_AL: begin
				if (m_step == 0) begin
					m_step = 1; load_byte(m_reg);
				end else if (m_step == 1) begin
					m_step = 2;
					if (m_rd) m_phase = P_ST0;
					else load_byte(m_data);
				end else if (m_step == 3) begin
					m_step = 4; m_shift = 0; m_bits = 0; m_phase = P_R0;
				end else m_phase = P_SP0;
			end
			P_R0: m_phase = P_RH;
			P_RH: begin
				m_shift = {m_shift[6:0], sda};
				m_bits = m_bits + 1;
				m_phase = P_RL;
			end
			P_RL: m_phase = (m_bits >= 8) ? P_RX : P_RH;
			P_RX: begin
				m_rxbyte = m_shift; m_phase = P_N0;
			end
			P_N0: m_phase = P_N1;
			P_N1: m_phase = P_N2;
			P_N2: m_phase = P_SP0;
			P_SP0: m_phase = P_SP1;
			P_SP1: m_phase = P_SP2;
			default: m_phase = P_IDLE;
		endcase
	endtask

	// one tick of the sequencer; returns the result of that tick
	task automatic predict_tick(input in_item_t it, output out_item_t r);
		logic scl, sdal, drv, done, b;
		scl = 1; sdal = 1; drv = 1; done = 0;
		if (m_phase == P_IDLE && (it.command == CMD_WRITE || it.command == CMD_READ)) begin
			m_dev = it.device_address; m_reg = it.register_address;
			m_data = it.write_data; m_rd = (it.command == CMD_READ);
			m_err = 0; m_step = 0; m_bits = 0; m_timer = 0; m_phase = P_ST0;
		end
		b = m_shift[7];
		case (m_phase)
			P_ST0: begin
				scl = (m_step == 0); sdal = 1;
			end
			P_ST1: begin
				scl = 1; sdal = 1;
			end
			P_ST2: begin
				scl = 1; sdal = 0;
			end
			P_BL1, P_WE0: begin
				scl = 0; sdal = m_sda_hold;
			end
			P_BL2: begin
				scl = 0; sdal = b;
			end
			P_BH: begin
				scl = 1; sdal = b;
			end
			P_WE1, P_N0, P_N2: begin
				scl = 0; sdal = 1;
			end
			P_AS, P_AW, P_RH: begin
				scl = 1; drv = 0;
			end
			P_AL, P_R0, P_RL, P_RX: begin
				scl = 0; drv = 0;
			end
			P_N1: begin
				scl = 1; sdal = 1;
			end
			P_SP0: begin
				scl = 0; sdal = 0;
			end
			P_SP1: begin
				scl = 1; sdal = 0;
			end
			default: begin
				scl = 1; sdal = 1;
			end
		endcase
		if (drv) m_sda_hold = sdal;
		if (m_phase == P_AW) begin
			if (!it.sda_sample) begin
				m_phase = P_AL; m_timer = 0;
			end else begin
				if (m_ackw != 8'hff) m_ackw++;
				if (m_ackw >= ge1(m_tmo)) begin
					m_err = 1; m_phase = P_SP0; m_timer = 0;
				end
			end
		end else if (m_phase != P_IDLE) begin
			if ({1'b0, m_timer} + 9'd1 >= {1'b0, ge1(m_half)}) begin
				m_timer = 0;
				if (m_phase == P_SP2) begin
					m_phase = P_IDLE; done = 1;
				end else advance_phase(it.sda_sample);
			end else m_timer = m_timer + 1;
		end
		r.scl_level = scl;
		r.sda_level = drv ? sdal : 1'b1;
		r.sda_drive = drv;
		r.busy_res = (m_phase != P_IDLE);
		r.done_res = done;
		r.read_data = m_rxbyte;
		r.ack_missing = m_err;
	endtask

	// --- result side: sample at rising edge, change pop at falling edge ---
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_ticks.size() == 0) report_mismatch("unexpected result", 0, 0);
			else begin
				want = expected_ticks.pop_front();
				if (out_item.scl_level != want.scl_level)
					report_mismatch("scl_level", out_item.scl_level, want.scl_level);
				if (out_item.sda_level != want.sda_level)
					report_mismatch("sda_level", out_item.sda_level, want.sda_level);
				if (out_item.sda_drive != want.sda_drive)
					report_mismatch("sda_drive", out_item.sda_drive, want.sda_drive);
				if (out_item.busy_res != want.busy_res)
					report_mismatch("busy_res", out_item.busy_res, want.busy_res);
				if (out_item.done_res != want.done_res)
					report_mismatch("done_res", out_item.done_res, want.done_res);
				if (out_item.read_data != want.read_data)
					report_mismatch("read_data", out_item.read_data, want.read_data);
				if (out_item.ack_missing != want.ack_missing)
					report_mismatch("ack_missing", out_item.ack_missing, want.ack_missing);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_rx) pop <= 1'b0;
		else if (rx_no_idle) pop <= 1'b1;
		else pop <= ($urandom_range(99) >= 29);
	end

	// global cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// one transaction on the input side; prediction done on acceptance.
	// push stays high on return so back-to-back ticks need no gap
	task automatic send_tick(input in_item_t it);
		out_item_t r;
		if (!tx_no_idle) begin
			while ($urandom_range(99) < 29) begin
				push <= 1'b0;
				@(negedge clk);
			end
		end
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_tick(it, r);
		expected_ticks.push_back(r);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_ticks.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_HALF_BIT) m_half = v;
		else m_tmo = v;
	endtask

	function automatic in_item_t mk(input logic [1:0] c, input logic [7:0] d,
			input logic [7:0] ra, input logic [7:0] wd, input logic s);
		in_item_t it;
		it.command = c; it.device_address = d; it.register_address = ra;
		it.write_data = wd; it.sda_sample = s;
		return it;
	endfunction

	// bus ticks until the transaction finishes; the slave acks with low SDA
	// unless told to miss, and returns random read bits
	task automatic run_transaction(input in_item_t req, input int miss_pct);
		in_item_t t;
		int guard;
		send_tick(req);
		guard = 0;
		while (m_phase != P_IDLE && guard < 20000) begin
			t = mk($urandom_range(3), $urandom, $urandom, $urandom, $urandom_range(1));
			if (m_phase == P_AW || m_phase == P_AS)
				t.sda_sample = ($urandom_range(99) < miss_pct);
			send_tick(t);
			guard++;
		end
	endtask

	// directed table: a row either carries an expected result or is predicted
	typedef struct {
		in_item_t it;
		bit       chk;
		out_item_t want;
	} dir_row_t;

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		out_item_t r;
		out_item_t idle_res;
		int n;
		model_reset();
		idle_res = '{scl_level:1, sda_level:1, sda_drive:1, busy_res:0, done_res:0,
			read_data:0, ack_missing:0};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// plain ticks after reset, command 3 as a tick, all-ones fields
		row.chk = 1; row.want = idle_res;
		row.it = mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0); rows.push_back(row);
		row.it = mk(CMD_SPARE, 8'hff, 8'hff, 8'hff, 1'b1); rows.push_back(row);
		row.it = mk(CMD_TICK, 8'hff, 8'hff, 8'hff, 1'b1); rows.push_back(row);
		row.it = mk(CMD_SPARE, 8'h00, 8'h00, 8'h00, 1'b0); rows.push_back(row);
		foreach (rows[i]) begin
			send_tick(rows[i].it);
			if (rows[i].chk) begin
				r = expected_ticks[$];
				if (r != rows[i].want) report_mismatch("directed row", r, rows[i].want);
			end
		end
		drain();

		// fastest timing: a write, a read, an odd address read, a missing ack
		write_reg(REG_HALF_BIT, 8'd0);
		write_reg(REG_ACK_TMO, 8'd0);
		run_transaction(mk(CMD_WRITE, 8'hff, 8'h00, 8'hff, 1'b0), 0);
		run_transaction(mk(CMD_READ, 8'h00, 8'hff, 8'h00, 1'b0), 0);
		run_transaction(mk(CMD_READ, 8'ha5, 8'h5a, 8'h33, 1'b1), 0);
		run_transaction(mk(CMD_WRITE, 8'h90, 8'h12, 8'h34, 1'b1), 100);
		// a request while busy is ignored
		send_tick(mk(CMD_WRITE, 8'h40, 8'h01, 8'h02, 1'b0));
		send_tick(mk(CMD_READ, 8'h41, 8'h03, 8'h04, 1'b0));
		run_transaction(mk(CMD_TICK, 0, 0, 0, 1'b0), 0);
		drain();

		// random part, one transaction or single tick per timing setting until the item target
		n = 0;
		while (sent < ITEM_TARGET) begin
			case (n % 4)
				0: begin
					write_reg(REG_HALF_BIT, 8'd0); write_reg(REG_ACK_TMO, 8'd1);
				end
				1: begin
					write_reg(REG_HALF_BIT, 8'd1);
					write_reg(REG_ACK_TMO, 8'($urandom_range(1, 6)));
				end
				2: begin
					write_reg(REG_HALF_BIT, 8'd0); write_reg(REG_ACK_TMO, 8'd3);
				end
				default: begin
					write_reg(REG_HALF_BIT, 8'd2);
					write_reg(REG_ACK_TMO, 8'd255);
				end
			endcase
			// second round runs with no idling on either side
			tx_no_idle = (n == 1);
			rx_no_idle = (n == 1);
			if (n == 0) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						stall_rx = 1'b1;
						repeat (60) @(negedge clk);
						stall_rx = 1'b0;
					end
				join_none
			end
			if ($urandom_range(99) < 85) begin
				run_transaction(mk(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom_range(1))), ack_miss_pct);
			end else begin
				send_tick(mk(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom_range(1))));
			end
			n++;
			// sender pauses until every result has come
			drain();
		end
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;

		drain();
		if (errors == 0) $display("testbench OK");
		else $display("testbench NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/imra_pkg.sv
sv/imra_front.sv
sv/imra_seq.sv
sv/imra_back.sv
sv/i2c_master_register_access.sv
dv/testbench.sv
